// ===== hw/rtl/sll_pkg.sv =====
// Shared types and constants of the static linked list unit.
// Depends on nothing; every other file of the unit but sll_ram imports it.
`timescale 1ns / 1ps

package sll_pkg;

  // Default sizes of the slot stores.
  localparam int unsigned SLL_DEPTH       = 1024;
  localparam int unsigned SLL_VALUE_WIDTH = 32;

  // Fixed field widths of the request and response beats.
  localparam int unsigned POS_W  = 10;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_e;

  // Datapath operations, one per controller state.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CHECK,
    OP_INS_FREE,
    OP_WALK,
    OP_PRED,
    OP_INS_LINK,
    OP_DEL_HEAD,
    OP_DEL_NEXT,
    OP_DEL_FREE,
    OP_EMIT
  } op_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    op_e  op;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_ok;
    logic is_delete;
    logic pos_one;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/sll_req_if.sv =====
// Request channel of the static linked list unit: valid/ready plus command fields.
// Depends on sll_pkg for the field widths.
`timescale 1ns / 1ps

interface sll_req_if import sll_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ===== hw/rtl/sll_rsp_if.sv =====
// Response channel of the static linked list unit: valid/ready plus status and length.
// Depends on sll_pkg for the field widths.
`timescale 1ns / 1ps

interface sll_rsp_if import sll_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [LEN_W-1:0] length;

  modport source (output valid, output status, output length, input ready);
  modport sink   (input valid, input status, input length, output ready);
endinterface

// ===== hw/rtl/static_linked_list_unit.sv =====
// Top level of the static linked list unit: request and response channels,
// sequencer and datapath. Depends on sll_pkg, sll_req_if, sll_rsp_if,
// sll_ctrl and sll_dpath.
`timescale 1ns / 1ps

// Usage
// A singly linked list is held in a link store and a data store of DEPTH
// slots, with a chain of free slots for allocation; up to DEPTH-2 elements.
// Each request beat on req_i is an insert (value placed before a 1-based
// position) or a delete (element at a position removed, its slot pushed on
// the free chain). Each request yields exactly one response beat on rsp_o
// with the status (ok, or error for a bad position or a full store, which
// changes nothing) and the list length after the operation.
// The response follows the check step alone for a refused request, the
// check and then the free-slot or head-delete step for position 1, and
// otherwise a walk from the list head, which follows one link per cycle
// through the single read port of the link memory and sets the throughput.
// One request is in work at a time; the next request beat is taken in the
// cycle after the previous response moves into the response register.
// Reset empties the list with all usable slots free. Untouched slots keep
// their reset links through a high-water mark, so no clearing pass is run.
// When the receiver stalls, the response beat holds in its register and the
// unit waits in its final step until that register frees up.

module static_linked_list_unit import sll_pkg::*; #(
  parameter int unsigned DEPTH       = SLL_DEPTH,
  parameter int unsigned VALUE_WIDTH = SLL_VALUE_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sll_req_if.sink    req_i,
  sll_rsp_if.source  rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  // The sequencer owns the request handshake; the datapath owns the
  // response register.
  sll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  sll_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .req_cmd_i      (req_i.cmd),
    .req_position_i (req_i.position),
    .req_value_i    (req_i.value),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_status_o   (rsp_o.status),
    .rsp_length_o   (rsp_o.length)
  );

endmodule

// ===== hw/rtl/sll_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/sll_ctrl.sv =====
// Sequencer of the static linked list unit: steps the datapath through one command.
// Depends on sll_pkg for the command and status structs.
`timescale 1ns / 1ps

module sll_ctrl import sll_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_FREE,
    S_WALK,
    S_PRED,
    S_INS_LINK,
    S_DEL_HEAD,
    S_DEL_NEXT,
    S_DEL_FREE,
    S_EMIT
  } state_e;

  state_e state_q;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctrl_o.accept = (state_q == S_IDLE) && req_valid_i;
    unique case (state_q)
      S_IDLE:     ctrl_o.op = OP_NONE;
      S_CHECK:    ctrl_o.op = OP_CHECK;
      S_INS_FREE: ctrl_o.op = OP_INS_FREE;
      S_WALK:     ctrl_o.op = OP_WALK;
      S_PRED:     ctrl_o.op = OP_PRED;
      S_INS_LINK: ctrl_o.op = OP_INS_LINK;
      S_DEL_HEAD: ctrl_o.op = OP_DEL_HEAD;
      S_DEL_NEXT: ctrl_o.op = OP_DEL_NEXT;
      S_DEL_FREE: ctrl_o.op = OP_DEL_FREE;
      S_EMIT:     ctrl_o.op = stat_i.out_free ? OP_EMIT : OP_NONE;
      default:    ctrl_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          priority if (!stat_i.req_ok)                     state_q <= S_EMIT;
          else if (!stat_i.is_delete)                      state_q <= S_INS_FREE;
          else if (stat_i.pos_one)                         state_q <= S_DEL_HEAD;
          else                                             state_q <= S_WALK;
        end
        S_INS_FREE: begin
          state_q <= stat_i.pos_one ? S_EMIT : S_WALK;
        end
        S_WALK: begin
          if (stat_i.walk_done) state_q <= S_PRED;
        end
        S_PRED: begin
          state_q <= stat_i.is_delete ? S_DEL_NEXT : S_INS_LINK;
        end
        S_INS_LINK: state_q <= S_EMIT;
        S_DEL_HEAD: state_q <= S_EMIT;
        S_DEL_NEXT: state_q <= S_DEL_FREE;
        S_DEL_FREE: state_q <= S_EMIT;
        S_EMIT: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sll_dpath.sv =====
// Datapath of the static linked list unit: link and data stores, list pointers,
// walk cursor and response register. Depends on sll_pkg and sll_ram.
`timescale 1ns / 1ps

module sll_dpath import sll_pkg::*; #(
  parameter int unsigned DEPTH       = SLL_DEPTH,
  parameter int unsigned VALUE_WIDTH = SLL_VALUE_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  output stat_t                    stat_o,
  input  logic                     req_cmd_i,
  input  logic [POS_W-1:0]         req_position_i,
  input  logic signed [DATA_W-1:0] req_value_i,
  input  logic                     rsp_ready_i,
  output logic                     rsp_valid_o,
  output logic                     rsp_status_o,
  output logic [LEN_W-1:0]         rsp_length_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned WW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam logic [AW-1:0] LAST_FREE = AW'(DEPTH - 2);

  // List state.
  logic [AW-1:0] free_head_q, list_head_q, count_q, hwm_q;
  logic          pend_q, rsp_valid_q;

  // Per-command working registers.
  cmd_e              cmd_q;
  logic [POS_W-1:0]  pos_q, cnt_q;
  logic [DATA_W-1:0] val_q;
  logic [AW-1:0]     cur_q, j_q, rd_slot_q;
  status_e           status_q;
  logic              rsp_status_q;
  logic [LEN_W-1:0]  rsp_length_q;

  logic [AW-1:0] rd_addr, link_raw, link_eff, walk_ptr;
  logic [AW-1:0] link_waddr, link_wdata;
  logic          link_we;
  logic [WW-1:0] pos_ext, count_ext;
  logic [63:0]   val_ext;
  logic          is_delete, pos_one;

  assign is_delete = (cmd_q == CMD_DELETE);
  assign pos_one   = (pos_q == POS_W'(1));
  assign pos_ext   = WW'(pos_q);
  assign count_ext = WW'(count_q);
  assign val_ext   = {32'b0, val_q};

  // Slots at or above the high-water mark were never written and still hold
  // their reset link: the next index, or null for the last two slots.
  always_comb begin
    if (rd_slot_q < hwm_q) begin
      link_eff = link_raw;
    end else if (rd_slot_q >= LAST_FREE) begin
      link_eff = '0;
    end else begin
      link_eff = rd_slot_q + AW'(1);
    end
  end

  assign walk_ptr = pend_q ? link_eff : cur_q;

  always_comb begin
    stat_o.is_delete = is_delete;
    stat_o.pos_one   = pos_one;
    stat_o.walk_done = (cnt_q == pos_q - POS_W'(1));
    stat_o.out_free  = !rsp_valid_q || rsp_ready_i;
    if (pos_q == '0) begin
      stat_o.req_ok = 1'b0;
    end else if (is_delete) begin
      stat_o.req_ok = (pos_ext <= count_ext);
    end else begin
      stat_o.req_ok = (pos_ext <= count_ext + WW'(1)) && (free_head_q != '0);
    end
  end

  always_comb begin
    unique case (ctrl_i.op)
      OP_CHECK: rd_addr = is_delete ? list_head_q : free_head_q;
      OP_WALK:  rd_addr = walk_ptr;
      OP_PRED:  rd_addr = link_eff;
      default:  rd_addr = cur_q;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = j_q;
    link_wdata = free_head_q;
    unique case (ctrl_i.op)
      OP_INS_FREE: begin
        link_we    = pos_one;
        link_wdata = list_head_q;
      end
      OP_PRED: begin
        link_we    = !is_delete;
        link_wdata = link_eff;
      end
      OP_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = j_q;
      end
      OP_DEL_HEAD: link_we = 1'b1;
      OP_DEL_NEXT: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = link_eff;
      end
      OP_DEL_FREE: link_we = 1'b1;
      default: link_we = 1'b0;
    endcase
  end

  sll_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (1'b1),
    .raddr_i (rd_addr),
    .rdata_o (link_raw)
  );

  // Element values are kept but never read back.
  sll_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.op == OP_INS_FREE),
    .waddr_i (j_q),
    .wdata_i (val_ext[VALUE_WIDTH-1:0]),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= AW'(1);
      list_head_q <= '0;
      count_q     <= '0;
      hwm_q       <= AW'(1);
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.accept) begin
        pend_q <= 1'b0;
      end
      // A new response may load in the same cycle as the old one leaves.
      if (ctrl_i.op == OP_EMIT) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (ctrl_i.op)
        OP_INS_FREE: begin
          free_head_q <= link_eff;
          if (j_q >= hwm_q) hwm_q <= j_q + AW'(1);
          if (pos_one) begin
            list_head_q <= j_q;
            count_q     <= count_q + AW'(1);
          end
        end
        OP_WALK:     pend_q <= 1'b1;
        OP_INS_LINK: count_q <= count_q + AW'(1);
        OP_DEL_HEAD: begin
          list_head_q <= link_eff;
          free_head_q <= j_q;
          count_q     <= count_q - AW'(1);
        end
        OP_DEL_FREE: begin
          free_head_q <= j_q;
          count_q     <= count_q - AW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_addr;
    if (ctrl_i.accept) begin
      cmd_q <= cmd_e'(req_cmd_i);
      pos_q <= req_position_i;
      val_q <= req_value_i;
      cur_q <= list_head_q;
      cnt_q <= POS_W'(1);
    end
    unique case (ctrl_i.op)
      OP_CHECK: begin
        status_q <= stat_o.req_ok ? STATUS_OK : STATUS_ERR;
        j_q      <= is_delete ? list_head_q : free_head_q;
      end
      OP_WALK: begin
        cur_q <= walk_ptr;
        if (!stat_o.walk_done) cnt_q <= cnt_q + POS_W'(1);
      end
      OP_PRED: begin
        if (is_delete) j_q <= link_eff;
      end
      OP_EMIT: begin
        rsp_status_q <= status_q;
        rsp_length_q <= count_ext[LEN_W-1:0];
      end
      default: ;
    endcase
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_length_o = rsp_length_q;

endmodule
